/* sv/gdfs_pkg.sv */
`timescale 1ns / 1ps
package gdfs_pkg;

  localparam int CMP_W   = 12;
  localparam int EPOCH_W = 8;
  localparam int SIZE_W  = 8;
  localparam int COORD_W = 7;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_VISITED  = 2'd0,
    STAT_FINISHED = 2'd1,
    STAT_ERROR    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_DONE  = 3'd4,
    DIR_SELF  = 3'd5
  } dir_e;

  typedef enum logic [2:0] {
    S_CLEAR = 3'd0,
    S_IDLE  = 3'd1,
    S_START = 3'd2,
    S_PROBE = 3'd3,
    S_LOAD  = 3'd4,
    S_CHECK = 3'd5
  } state_e;

  typedef enum logic {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } reg_idx_e;

  typedef struct packed {
    cmd_e               command;
    logic [COORD_W-1:0] source_row;
    logic [COORD_W-1:0] source_col;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] visit_row;
    logic [COORD_W-1:0] visit_col;
    status_e            status;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] grid_rows;
    logic [SIZE_W-1:0] grid_cols;
  } cfg_t;

  typedef struct packed {
    logic             on_grid;
    logic [CMP_W-1:0] row;
    logic [CMP_W-1:0] col;
  } step_res_t;

  function automatic dir_e next_dir(input dir_e d);
    dir_e n;
    unique case (d)
      DIR_UP:    n = DIR_DOWN;
      DIR_DOWN:  n = DIR_LEFT;
      DIR_LEFT:  n = DIR_RIGHT;
      default:   n = DIR_DONE;
    endcase
    return n;
  endfunction

endpackage

/* sv/gdfs_stream_if.sv */
`timescale 1ns / 1ps
interface gdfs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/grid_dfs_traversal_top.sv */
`timescale 1ns / 1ps
// channel   dir  handshake       payload
// in_i      in   valid/ready     command, source_row, source_col
// out_o     out  valid/ready     visit_row, visit_col, status
// apb       in   psel/penable    grid_rows @0x0, grid_cols @0x4
//
// start: accept, then S_START marks the source; next with no walk: answered on accept;
// next: accept, then S_PROBE per neighbor, S_CHECK per one on the grid, S_LOAD per popped
// frame but the last; the single visited-map port and the shared neighbor unit set this.
// after reset, and on every 255th start, a clearing pass over all MAX_ROWS*MAX_COLS cells
// sweeps the visited map; no transaction is accepted meanwhile.
// one output register holds a result; input is accepted only once it is free or draining.
module grid_dfs_traversal_top
  import gdfs_pkg::*;
#(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  gdfs_stream_if.sink       in_i,
  gdfs_stream_if.source     out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);
  localparam int CELLS   = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DEPTH_W = $clog2(CELLS + 1);
  localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int FR_W    = RW + CW + 3;

  cfg_t cfg;

  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_cnt_q, clr_cnt_d;
  logic                start_pend_q, start_pend_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic                finished_q, finished_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;
  logic [COORD_W-1:0]  src_row_q, src_row_d, src_col_q, src_col_d;
  logic [RW-1:0]       top_row_q, top_row_d, nb_row_q, nb_row_d;
  logic [CW-1:0]       top_col_q, top_col_d, nb_col_q, nb_col_d;
  dir_e                top_dir_q, top_dir_d;
  logic [ADDR_W-1:0]   nb_addr_q, nb_addr_d;

  logic                in_fire, clr_last, visited_hit;
  logic [DEPTH_W-1:0]  depth_m1, depth_m2;
  logic [CMP_W-1:0]    su_row, su_col;
  dir_e                su_dir;
  step_res_t           su_res;
  logic [ADDR_W-1:0]   su_addr;
  logic [CMP_W-1:0]    nb_row_w, nb_col_w;

  logic                vis_we, stk_we;
  logic [ADDR_W-1:0]   vis_addr, stk_addr;
  logic [EPOCH_W-1:0]  vis_wdata, vis_rdata;
  logic [FR_W-1:0]     stk_wdata, stk_rdata;

  gdfs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  gdfs_step_unit #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_step (
    .cfg_i  (cfg),
    .row_i  (su_row),
    .col_i  (su_col),
    .dir_i  (su_dir),
    .res_o  (su_res),
    .addr_o (su_addr)
  );

  // visited map holds the epoch of the start that marked each cell
  gdfs_ram #(
    .WIDTH (EPOCH_W),
    .DEPTH (CELLS)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .addr_i  (vis_addr),
    .wdata_i (vis_wdata),
    .rdata_o (vis_rdata)
  );

  // stack holds every frame below the top one, which lives in registers
  gdfs_ram #(
    .WIDTH (FR_W),
    .DEPTH (CELLS)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  assign clr_last    = (clr_cnt_q == ADDR_W'(CELLS - 1));
  assign visited_hit = (vis_rdata == epoch_q);
  assign depth_m1    = depth_q - DEPTH_W'(1);
  assign depth_m2    = depth_q - DEPTH_W'(2);
  assign stk_wdata   = {top_row_q, top_col_q, top_dir_q};
  assign nb_row_w    = CMP_W'(nb_row_q);
  assign nb_col_w    = CMP_W'(nb_col_q);

  assign su_row = (state_q == S_START) ? CMP_W'(src_row_q) : CMP_W'(top_row_q);
  assign su_col = (state_q == S_START) ? CMP_W'(src_col_q) : CMP_W'(top_col_q);
  assign su_dir = (state_q == S_START) ? DIR_SELF : top_dir_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (clr_last) begin
          state_d = start_pend_q ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.payload.command == CMD_START) begin
            state_d = (epoch_q == EPOCH_MAX) ? S_CLEAR : S_START;
          end else if (depth_q != '0) begin
            state_d = S_PROBE;
          end
        end
      end
      S_START: state_d = S_IDLE;
      S_PROBE: begin
        if (top_dir_q == DIR_DONE) begin
          state_d = (depth_q == DEPTH_W'(1)) ? S_IDLE : S_LOAD;
        end else if (su_res.on_grid) begin
          state_d = S_CHECK;
        end
      end
      S_LOAD:  state_d = S_PROBE;
      S_CHECK: state_d = visited_hit ? S_PROBE : S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_d    = clr_cnt_q;
    start_pend_d = start_pend_q;
    epoch_d      = epoch_q;
    depth_d      = depth_q;
    finished_d   = finished_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    out_d        = out_q;
    src_row_d    = src_row_q;
    src_col_d    = src_col_q;
    top_row_d    = top_row_q;
    top_col_d    = top_col_q;
    top_dir_d    = top_dir_q;
    nb_row_d     = nb_row_q;
    nb_col_d     = nb_col_q;
    nb_addr_d    = nb_addr_q;
    vis_we       = 1'b0;
    vis_addr     = su_addr;
    vis_wdata    = epoch_q;
    stk_we       = 1'b0;
    stk_addr     = depth_m2[ADDR_W-1:0];

    unique case (state_q)
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_addr  = clr_cnt_q;
        vis_wdata = '0;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_last) begin
          epoch_d      = EPOCH_W'(1);
          start_pend_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.payload.command == CMD_START) begin
            src_row_d  = in_i.payload.source_row;
            src_col_d  = in_i.payload.source_col;
            finished_d = 1'b0;
            depth_d    = '0;
            if (epoch_q == EPOCH_MAX) begin
              start_pend_d = 1'b1;
              clr_cnt_d    = '0;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end else if (depth_q == '0) begin
            out_valid_d     = 1'b1;
            out_d.visit_row = '0;
            out_d.visit_col = '0;
            out_d.status    = finished_q ? STAT_FINISHED : STAT_ERROR;
          end
        end
      end
      S_START: begin
        out_valid_d     = 1'b1;
        out_d.visit_row = '0;
        out_d.visit_col = '0;
        out_d.status    = STAT_ERROR;
        if (su_res.on_grid) begin
          vis_we          = 1'b1;
          depth_d         = DEPTH_W'(1);
          top_row_d       = su_res.row[RW-1:0];
          top_col_d       = su_res.col[CW-1:0];
          top_dir_d       = DIR_UP;
          out_d.visit_row = su_res.row[COORD_W-1:0];
          out_d.visit_col = su_res.col[COORD_W-1:0];
          out_d.status    = STAT_VISITED;
        end
      end
      S_PROBE: begin
        if (top_dir_q == DIR_DONE) begin
          depth_d = depth_m1;
          if (depth_q == DEPTH_W'(1)) begin
            finished_d      = 1'b1;
            out_valid_d     = 1'b1;
            out_d.visit_row = '0;
            out_d.visit_col = '0;
            out_d.status    = STAT_FINISHED;
          end
        end else begin
          top_dir_d = next_dir(top_dir_q);
          nb_row_d  = su_res.row[RW-1:0];
          nb_col_d  = su_res.col[CW-1:0];
          nb_addr_d = su_addr;
        end
      end
      S_LOAD: begin
        top_row_d = stk_rdata[FR_W-1 -: RW];
        top_col_d = stk_rdata[CW+2:3];
        top_dir_d = dir_e'(stk_rdata[2:0]);
      end
      S_CHECK: begin
        if (!visited_hit) begin
          vis_we          = 1'b1;
          vis_addr        = nb_addr_q;
          stk_we          = 1'b1;
          stk_addr        = depth_m1[ADDR_W-1:0];
          depth_d         = depth_q + DEPTH_W'(1);
          top_row_d       = nb_row_q;
          top_col_d       = nb_col_q;
          top_dir_d       = DIR_UP;
          out_valid_d     = 1'b1;
          out_d.visit_row = nb_row_w[COORD_W-1:0];
          out_d.visit_col = nb_col_w[COORD_W-1:0];
          out_d.status    = STAT_VISITED;
        end
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_cnt_q    <= '0;
      start_pend_q <= 1'b0;
      epoch_q      <= EPOCH_W'(1);
      depth_q      <= '0;
      finished_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      start_pend_q <= start_pend_d;
      epoch_q      <= epoch_d;
      depth_q      <= depth_d;
      finished_q   <= finished_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    src_row_q <= src_row_d;
    src_col_q <= src_col_d;
    top_row_q <= top_row_d;
    top_col_q <= top_col_d;
    top_dir_q <= top_dir_d;
    nb_row_q  <= nb_row_d;
    nb_col_q  <= nb_col_d;
    nb_addr_q <= nb_addr_d;
  end
endmodule

/* sv/gdfs_ram.sv */
`timescale 1ns / 1ps
module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

/* sv/gdfs_cfg.sv */
`timescale 1ns / 1ps
module gdfs_cfg
  import gdfs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);
  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_GRID_ROWS: cfg_d.grid_rows = pwdata[SIZE_W-1:0];
        REG_GRID_COLS: cfg_d.grid_cols = pwdata[SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_ROWS: prdata = APB_DW'(cfg_q.grid_rows);
      REG_GRID_COLS: prdata = APB_DW'(cfg_q.grid_cols);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_rows <= SIZE_W'(128);
      cfg_q.grid_cols <= SIZE_W'(128);
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

/* sv/gdfs_step_unit.sv */
`timescale 1ns / 1ps
module gdfs_step_unit
  import gdfs_pkg::*;
#(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128,
  parameter int ADDR_W   = 14
) (
  input  cfg_t              cfg_i,
  input  logic [CMP_W-1:0]  row_i,
  input  logic [CMP_W-1:0]  col_i,
  input  dir_e              dir_i,
  output step_res_t         res_o,
  output logic [ADDR_W-1:0] addr_o
);
  logic [CMP_W-1:0] rows_use, cols_use;
  logic [CMP_W-1:0] nrow, ncol;

  // size in use saturates at the grid limit
  assign rows_use = (CMP_W'(cfg_i.grid_rows) > CMP_W'(MAX_ROWS)) ?
                    CMP_W'(MAX_ROWS) : CMP_W'(cfg_i.grid_rows);
  assign cols_use = (CMP_W'(cfg_i.grid_cols) > CMP_W'(MAX_COLS)) ?
                    CMP_W'(MAX_COLS) : CMP_W'(cfg_i.grid_cols);

  // a step off the low edge wraps to a large value and fails the bound check
  always_comb begin
    nrow = row_i;
    ncol = col_i;
    unique case (dir_i)
      DIR_UP:    nrow = row_i - CMP_W'(1);
      DIR_DOWN:  nrow = row_i + CMP_W'(1);
      DIR_LEFT:  ncol = col_i - CMP_W'(1);
      DIR_RIGHT: ncol = col_i + CMP_W'(1);
      default: begin
        nrow = row_i;
        ncol = col_i;
      end
    endcase
  end

  assign res_o.on_grid = (nrow < rows_use) && (ncol < cols_use);
  assign res_o.row     = nrow;
  assign res_o.col     = ncol;
  assign addr_o        = ADDR_W'(nrow) * ADDR_W'(MAX_COLS) + ADDR_W'(ncol);
endmodule

/* sv/gdfs_checker.sv */
`timescale 1ns / 1ps
module gdfs_checker
  import gdfs_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input out_item_t         out_payload_i,
  input logic              psel_i,
  input logic              penable_i,
  input logic              pwrite_i,
  input logic              pready_i,
  input logic [APB_AW-1:0] paddr_i,
  input logic [APB_DW-1:0] pwdata_i,
  input logic [APB_DW-1:0] prdata_i
);
  logic cfg_wr;
  assign cfg_wr = psel_i & penable_i & pwrite_i & pready_i;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // coordinates are zero on anything but a visit
  a_zero_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.status != STAT_VISITED |->
      out_payload_i.visit_row == '0 && out_payload_i.visit_col == '0)
    else $error("nonzero coordinates without a visit");

  // one transaction at a time: after an accept the block is busy or has its result out
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i || out_valid_i)
    else $error("input accepted again without a result");

  // a size register reads back what was just written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) && $past(cfg_wr) && psel_i && !pwrite_i &&
      paddr_i[2] == $past(paddr_i[2]) |->
      prdata_i[SIZE_W-1:0] == $past(pwdata_i[SIZE_W-1:0]))
    else $error("size register readback mismatch");
endmodule

bind grid_dfs_traversal_top gdfs_checker u_gdfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload),
  .psel_i        (psel),
  .penable_i     (penable),
  .pwrite_i      (pwrite),
  .pready_i      (pready),
  .paddr_i       (paddr),
  .pwdata_i      (pwdata),
  .prdata_i      (prdata)
);

/* verif/grid_dfs_traversal_top_tb.sv */
`timescale 1ns / 1ps
module grid_dfs_traversal_top_tb;
  import gdfs_pkg::*;

  localparam int MAX_R          = 128;
  localparam int MAX_C          = 128;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int TAIL_CYCLES    = 64;

  typedef struct {
    int   row;
    int   col;
    dir_e dir;
  } frame_t;

  logic clk = 1'b0;
  logic rst_ni;

  gdfs_stream_if #(.T(in_item_t))  in_ch ();
  gdfs_stream_if #(.T(out_item_t)) out_ch ();

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  grid_dfs_traversal_top #(
    .MAX_ROWS(MAX_R),
    .MAX_COLS(MAX_C)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // walk state mirrored from the block
  int        cell_mark [MAX_R][MAX_C];
  int        epoch = 0;
  frame_t    dfs_stack[$];
  bit        walk_done = 1'b0;
  int        cfg_rows = 128;
  int        cfg_cols = 128;

  out_item_t visit_q[$];
  int        err_count = 0;
  int        stall_cycles = 0;
  bit        no_idle = 1'b0;

  function automatic int rows_used();
    return (cfg_rows > MAX_R) ? MAX_R : cfg_rows;
  endfunction

  function automatic int cols_used();
    return (cfg_cols > MAX_C) ? MAX_C : cfg_cols;
  endfunction

  function automatic bit in_grid(int r, int c);
    return r >= 0 && r < rows_used() && c >= 0 && c < cols_used();
  endfunction

  function automatic out_item_t mark_cell(int r, int c);
    out_item_t res;
    frame_t    f;
    cell_mark[r][c] = epoch;
    f.row = r;
    f.col = c;
    f.dir = DIR_UP;
    dfs_stack.push_back(f);
    res.visit_row = COORD_W'(r);
    res.visit_col = COORD_W'(c);
    res.status    = STAT_VISITED;
    return res;
  endfunction

  function automatic out_item_t dfs_step(in_item_t it);
    out_item_t res;
    frame_t    f;
    int        nr;
    int        nc;
    int        top;
    res = '0;
    if (it.command == CMD_START) begin
      epoch++;
      dfs_stack.delete();
      walk_done = 1'b0;
      if (in_grid(int'(it.source_row), int'(it.source_col))) begin
        res = mark_cell(int'(it.source_row), int'(it.source_col));
      end else begin
        res.status = STAT_ERROR;
      end
      return res;
    end
    if (dfs_stack.size() == 0) begin
      res.status = walk_done ? STAT_FINISHED : STAT_ERROR;
      return res;
    end
    while (dfs_stack.size() > 0) begin
      top = dfs_stack.size() - 1;
      f = dfs_stack[top];
      if (f.dir != DIR_DONE) begin
        nr = f.row;
        nc = f.col;
        case (f.dir)
          DIR_UP:   nr = f.row - 1;
          DIR_DOWN: nr = f.row + 1;
          DIR_LEFT: nc = f.col - 1;
          default:  nc = f.col + 1;
        endcase
        f.dir = dir_e'(f.dir + 3'd1);
        dfs_stack[top] = f;
        if (in_grid(nr, nc) && cell_mark[nr][nc] != epoch) begin
          res = mark_cell(nr, nc);
          return res;
        end
      end else begin
        void'(dfs_stack.pop_back());
      end
    end
    walk_done = 1'b1;
    res.status = STAT_FINISHED;
    return res;
  endfunction

  // all tasks below start and end at a falling edge
  task automatic send_item(cmd_e cmd, int row, int col);
    in_item_t it;
    int       gap;
    gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it.command    = cmd;
    it.source_row = COORD_W'(row);
    it.source_col = COORD_W'(col);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    visit_q.push_back(dfs_step(it));
    @(negedge clk);
  endtask

  task automatic send_start(int row, int col);
    send_item(CMD_START, row, col);
  endtask

  task automatic send_next(int n);
    repeat (n) send_item(CMD_NEXT, $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (visit_q.size() != 0);
  endtask

  task automatic write_reg(reg_idx_e idx, int val);
    logic [SIZE_W-1:0] v;
    v = SIZE_W'(val);
    wait_drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= APB_DW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_GRID_ROWS) begin
      cfg_rows = int'(v);
    end else begin
      cfg_cols = int'(v);
    end
    @(negedge clk);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[SIZE_W-1:0] !== v) begin
      $display("%0t readback mismatch reg %s: expected %0d, got %0d", $time, idx.name(),
               v, prdata[SIZE_W-1:0]);
      err_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_grid(int rows, int cols);
    write_reg(REG_GRID_ROWS, rows);
    write_reg(REG_GRID_COLS, cols);
  endtask

  task automatic test_reset_defaults();
    send_next(1);
    send_start(127, 127);
    send_next(3);
    send_start(0, 0);
    send_next(2);
  endtask

  task automatic test_single_cell();
    set_grid(1, 1);
    send_start(0, 0);
    send_next(2);
    send_start(1, 0);
    send_next(1);
    send_start(0, 127);
  endtask

  task automatic test_size_extremes();
    set_grid(0, 5);
    send_start(0, 0);
    send_next(1);
    set_grid(255, 200);
    send_start(127, 127);
    send_next(2);
  endtask

  task automatic test_full_walk();
    set_grid(2, 3);
    send_start(1, 1);
    send_next(7);
  endtask

  task automatic test_resize_mid_walk();
    set_grid(6, 6);
    send_start(2, 2);
    send_next(5);
    write_reg(REG_GRID_COLS, 3);
    send_next(6);
    write_reg(REG_GRID_ROWS, 200);
    send_next(4);
  endtask

  task automatic pick_grid();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      set_grid($urandom_range(1, 12), $urandom_range(1, 12));
    end else if (r < 9) begin
      set_grid($urandom_range(1, 128), $urandom_range(1, 128));
    end else if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_GRID_ROWS, $urandom_range(0, 255));
    end else begin
      set_grid($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  task automatic test_random_walks(int n_items);
    int sent;
    int pick;
    int cells;
    int steps;
    int half;
    int sr;
    int sc;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 5) == 0) pick_grid();
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        sr = (rows_used() > 0) ? $urandom_range(0, rows_used() - 1) : $urandom_range(0, 127);
        sc = (cols_used() > 0) ? $urandom_range(0, cols_used() - 1) : $urandom_range(0, 127);
        cells = rows_used() * cols_used();
        steps = cells + $urandom_range(0, 2);
        if (steps > 60 || $urandom_range(0, 4) == 0) steps = $urandom_range(1, 60);
        send_start(sr, sc);
        if ($urandom_range(0, 19) == 0) begin
          half = steps / 2;
          send_next(half);
          set_grid($urandom_range(1, 12), $urandom_range(1, 12));
          send_next(steps - half);
        end else begin
          send_next(steps);
        end
        sent += steps + 1;
      end else if (pick < 90) begin
        if (rows_used() < MAX_R) begin
          sr = $urandom_range(rows_used(), 127);
          sc = $urandom_range(0, 127);
        end else if (cols_used() < MAX_C) begin
          sr = $urandom_range(0, 127);
          sc = $urandom_range(cols_used(), 127);
        end else begin
          sr = $urandom_range(0, 127);
          sc = $urandom_range(0, 127);
        end
        steps = $urandom_range(0, 2);
        send_start(sr, sc);
        send_next(steps);
        sent += steps + 1;
      end else begin
        steps = $urandom_range(1, 4);
        send_next(steps);
        sent += steps;
      end
    end
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_walks(200);
  endtask

  // result sink stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no transaction for %0d cycles", $time, stall_cycles);
        $display("grid_dfs_traversal_top_tb: done, errors");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (visit_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got row %0d col %0d status %0d",
                   $time, got.visit_row, got.visit_col, got.status);
          err_count++;
        end else begin
          want = visit_q.pop_front();
          if (got.visit_row !== want.visit_row) begin
            $display("%0t visit_row mismatch: expected %0d, got %0d", $time,
                     want.visit_row, got.visit_row);
            err_count++;
          end
          if (got.visit_col !== want.visit_col) begin
            $display("%0t visit_col mismatch: expected %0d, got %0d", $time,
                     want.visit_col, got.visit_col);
            err_count++;
          end
          if (got.status !== want.status) begin
            $display("%0t status mismatch: expected %0d, got %0d", $time,
                     want.status, got.status);
            err_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (10) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_single_cell();
    test_size_extremes();
    test_full_walk();
    test_resize_mid_walk();
    test_random_walks(1300);
    test_back_to_back();

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (visit_q.size() != 0) begin
      $display("%0t %0d results never arrived", $time, visit_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("grid_dfs_traversal_top_tb: done, clean");
    end else begin
      $display("grid_dfs_traversal_top_tb: done, errors");
    end
    $finish;
  end

endmodule

/* grid_dfs_traversal_top.f */
sv/gdfs_pkg.sv
sv/gdfs_stream_if.sv
sv/gdfs_ram.sv
sv/gdfs_cfg.sv
sv/gdfs_step_unit.sv
sv/grid_dfs_traversal_top.sv
sv/gdfs_checker.sv
verif/grid_dfs_traversal_top_tb.sv
